// File: rtl/text_encoding_sniffer_defines.svh
// Assertion macros shared by the text encoding sniffer RTL.
`ifndef TEXT_ENCODING_SNIFFER_DEFINES_SVH
`define TEXT_ENCODING_SNIFFER_DEFINES_SVH

`ifndef ASSERT_OFF
`define TES_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TES_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define TES_ASSERT(lbl, clk, rst_n, prop, msg)
`define TES_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

// File: rtl/tes_pkg.sv
// Package with the widths, encoding codes and counter indexes of the sniffer.
`timescale 1ns / 1ps
package tes_pkg;

    localparam int COUNT_WIDTH = 32;

    typedef enum logic [2:0] {
        ENC_NONE    = 3'd0,
        ENC_UTF8    = 3'd1,
        ENC_UTF16LE = 3'd2,
        ENC_UTF16BE = 3'd3,
        ENC_UTF32LE = 3'd4,
        ENC_UTF32BE = 3'd5,
        ENC_UTF7    = 3'd6,
        ENC_UCS4    = 3'd7
    } t_enc;

    localparam int NL_32LE = 0;
    localparam int NL_32BE = 1;
    localparam int NL_16LE = 2;
    localparam int NL_16BE = 3;

    localparam int ERR_UTF8   = 0;
    localparam int ERR_ZERO32 = 1;
    localparam int ERR_ZERO16 = 2;
    localparam int ERR_NULL   = 3;

endpackage

// File: rtl/tes_in_if.sv
// Byte stream channel into the sniffer.
`timescale 1ns / 1ps
interface tes_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: rtl/tes_out_if.sv
// Verdict channel out of the sniffer.
`timescale 1ns / 1ps
interface tes_out_if;
    logic          valid;
    logic          ready;
    tes_pkg::t_enc encoding;
    logic [2:0]    mark_bytes;
    logic          detected;
    logic          binary_suspect;

    modport source (output valid, output encoding, output mark_bytes, output detected,
                    output binary_suspect, input ready);
    modport sink (input valid, input encoding, input mark_bytes, input detected,
                  input binary_suspect, output ready);
endinterface

// File: rtl/text_encoding_sniffer.sv
// Top level of the text encoding sniffer: byte scan, verdict stage and output register.
//
// The block reads a file one byte per transaction on i_in (data_byte, with
// last_byte set on the final byte) and gives one verdict transaction on o_res
// for each file: encoding, byte-order mark length, detected and binary_suspect.
// Bytes that are not last produce nothing.
// Every accepted byte updates the scan state (head bytes, size, UTF-8 status,
// word flags and newline counters) in the cycle it is accepted, so the block
// takes one byte per cycle while i_in.ready is high. The last byte also copies
// the final state into a snapshot register and clears the scan state, so the
// next byte starts a new file at once. The verdict is formed from the snapshot
// and lands in the output register as soon as that is free: o_res.valid rises
// at the clock edge that moves the snapshot into the output register.
// When the receiver stalls, one verdict waits in the output register and one
// in the snapshot; only then does i_in.ready fall, and it rises again as soon
// as the receiver takes a verdict.
// A synchronous active-low reset clears the scan state and both valid flags.
`timescale 1ns / 1ps
`include "text_encoding_sniffer_defines.svh"
module text_encoding_sniffer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tes_in_if.sink           i_in,
    tes_out_if.source        o_res
);

    localparam int CW = tes_pkg::COUNT_WIDTH;
    localparam int TW = CW + 9;

    // Scan state.
    logic [39:0]   r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_pending, n_pending;
    logic [23:0]   r_recent, n_recent;
    logic [3:0]    r_flags, n_flags;
    logic [CW-1:0] r_nl [4];
    logic [CW-1:0] n_nl [4];
    logic [1:0]    r_phase, n_phase;

    // Snapshot of a finished file.
    logic          r_fin_valid;
    logic [39:0]   r_fin_head;
    logic [CW-1:0] r_fin_count;
    logic [3:0]    r_fin_flags;
    logic [CW-1:0] r_fin_nl [4];

    // Output register.
    logic          r_out_valid;
    tes_pkg::t_enc r_out_enc;
    logic [2:0]    r_out_mark;
    logic          r_out_det;
    logic          r_out_bin;

    logic out_can_load;
    logic fin_move;
    logic in_accept;
    logic [7:0] b;

    assign out_can_load = !r_out_valid || o_res.ready;
    assign fin_move     = r_fin_valid && out_can_load;
    assign i_in.ready   = !r_fin_valid || out_can_load;
    assign in_accept    = i_in.valid && i_in.ready;
    assign b            = i_in.data_byte;

    always_comb begin
        logic [7:0] r0, r1, r2;
        logic mid0;
        r0 = r_recent[7:0];
        r1 = r_recent[15:8];
        r2 = r_recent[23:16];
        mid0 = (r1 == 8'h00) && (r0 == 8'h00);

        n_head = r_head;
        for (int i = 0; i < 5; i++) begin
            if (r_count == CW'(i)) begin
                n_head[8*i +: 8] = b;
            end
        end
        n_count = (r_count == {CW{1'b1}}) ? r_count : r_count + 1'b1;

        n_flags   = r_flags;
        n_pending = r_pending;
        if (b == 8'h00) begin
            n_flags[tes_pkg::ERR_NULL] = 1'b1;
        end

        if (r_pending == 2'd0) begin
            if ((b & 8'hC0) == 8'h80 || b == 8'h00) begin
                n_flags[tes_pkg::ERR_UTF8] = 1'b1;
            end else if ((b & 8'h80) == 8'h00) begin
                n_pending = 2'd0;
            end else if ((b & 8'hE0) == 8'hC0) begin
                n_pending = 2'd1;
            end else if ((b & 8'hF0) == 8'hE0) begin
                n_pending = 2'd2;
            end else if ((b & 8'hF8) == 8'hF0) begin
                n_pending = 2'd3;
            end else begin
                n_flags[tes_pkg::ERR_UTF8] = 1'b1;
            end
        end else if ((b & 8'hC0) == 8'h80) begin
            n_pending = r_pending - 2'd1;
        end else begin
            n_flags[tes_pkg::ERR_UTF8] = 1'b1;
            n_pending = 2'd0;
        end

        for (int k = 0; k < 4; k++) begin
            n_nl[k] = r_nl[k];
        end
        if (r_phase[0]) begin
            if (r0 == 8'h00 && b == 8'h00) begin
                n_flags[tes_pkg::ERR_ZERO16] = 1'b1;
            end
            if (r0 == 8'h0A && b == 8'h00 && r_nl[tes_pkg::NL_16LE] != {CW{1'b1}}) begin
                n_nl[tes_pkg::NL_16LE] = r_nl[tes_pkg::NL_16LE] + 1'b1;
            end
            if (r0 == 8'h00 && b == 8'h0A && r_nl[tes_pkg::NL_16BE] != {CW{1'b1}}) begin
                n_nl[tes_pkg::NL_16BE] = r_nl[tes_pkg::NL_16BE] + 1'b1;
            end
        end
        if (r_phase == 2'd3) begin
            if (r2 == 8'h00 && mid0 && b == 8'h00) begin
                n_flags[tes_pkg::ERR_ZERO32] = 1'b1;
            end
            if (r2 == 8'h0A && mid0 && b == 8'h00 && r_nl[tes_pkg::NL_32LE] != {CW{1'b1}}) begin
                n_nl[tes_pkg::NL_32LE] = r_nl[tes_pkg::NL_32LE] + 1'b1;
            end
            if (r2 == 8'h00 && mid0 && b == 8'h0A && r_nl[tes_pkg::NL_32BE] != {CW{1'b1}}) begin
                n_nl[tes_pkg::NL_32BE] = r_nl[tes_pkg::NL_32BE] + 1'b1;
            end
        end

        n_recent = {r_recent[15:0], b};
        n_phase  = r_phase + 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_pending <= '0;
            r_recent  <= '0;
            r_flags   <= '0;
            r_phase   <= '0;
            for (int k = 0; k < 4; k++) begin
                r_nl[k] <= '0;
            end
        end else if (in_accept) begin
            if (i_in.last_byte) begin
                r_head    <= '0;
                r_count   <= '0;
                r_pending <= '0;
                r_recent  <= '0;
                r_flags   <= '0;
                r_phase   <= '0;
                for (int k = 0; k < 4; k++) begin
                    r_nl[k] <= '0;
                end
            end else begin
                r_head    <= n_head;
                r_count   <= n_count;
                r_pending <= n_pending;
                r_recent  <= n_recent;
                r_flags   <= n_flags;
                r_phase   <= n_phase;
                for (int k = 0; k < 4; k++) begin
                    r_nl[k] <= n_nl[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (in_accept && i_in.last_byte) begin
            r_fin_valid <= 1'b1;
        end else if (fin_move) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_in.last_byte) begin
            r_fin_head  <= n_head;
            r_fin_count <= n_count;
            r_fin_flags <= n_flags;
            for (int k = 0; k < 4; k++) begin
                r_fin_nl[k] <= n_nl[k];
            end
        end
    end

    // Verdict from the snapshot. A newline count c exceeds size/N exactly when N*c > size.
    tes_pkg::t_enc v_enc;
    logic [2:0]    v_mark;
    logic          v_det;
    logic          v_bin;

    always_comb begin
        logic [7:0] h0, h1, h2, h3, h4;
        logic ge2, ge3, ge4, ge5;
        logic [TW-1:0] size_w;
        logic [TW-1:0] c32le, c32be, c16le, c16be;
        logic [TW-1:0] t32le, t32be, t16le, t16be;
        h0 = r_fin_head[7:0];
        h1 = r_fin_head[15:8];
        h2 = r_fin_head[23:16];
        h3 = r_fin_head[31:24];
        h4 = r_fin_head[39:32];
        ge2 = r_fin_count >= CW'(2);
        ge3 = r_fin_count >= CW'(3);
        ge4 = r_fin_count >= CW'(4);
        ge5 = r_fin_count >= CW'(5);
        size_w = {9'b0, r_fin_count};
        c32le = {9'b0, r_fin_nl[tes_pkg::NL_32LE]};
        c32be = {9'b0, r_fin_nl[tes_pkg::NL_32BE]};
        c16le = {9'b0, r_fin_nl[tes_pkg::NL_16LE]};
        c16be = {9'b0, r_fin_nl[tes_pkg::NL_16BE]};
        t32le = (c32le << 8) + (c32le << 7) + (c32le << 4);
        t32be = (c32be << 8) + (c32be << 7) + (c32be << 4);
        t16le = (c16le << 7) + (c16le << 6) + (c16le << 3);
        t16be = (c16be << 7) + (c16be << 6) + (c16be << 3);

        v_enc  = tes_pkg::ENC_NONE;
        v_mark = 3'd0;
        v_det  = 1'b1;
        v_bin  = 1'b0;
        if (ge4 && h0 == 8'hFF && h1 == 8'hFE && h2 == 8'h00 && h3 == 8'h00) begin
            v_enc = tes_pkg::ENC_UTF32LE;
            v_mark = 3'd4;
        end else if (ge4 && h0 == 8'hFE && h1 == 8'hFF && h2 == 8'h00 && h3 == 8'h00) begin
            v_enc = tes_pkg::ENC_UCS4;
        end else if (ge4 && h0 == 8'h00 && h1 == 8'h00 && h2 == 8'hFE && h3 == 8'hFF) begin
            v_enc = tes_pkg::ENC_UTF32BE;
            v_mark = 3'd4;
        end else if (ge4 && h0 == 8'h00 && h1 == 8'h00 && h2 == 8'hFF && h3 == 8'hFE) begin
            v_enc = tes_pkg::ENC_UCS4;
        end else if (ge2 && h0 == 8'hFF && h1 == 8'hFE) begin
            v_enc = tes_pkg::ENC_UTF16LE;
            v_mark = 3'd2;
        end else if (ge2 && h0 == 8'hFE && h1 == 8'hFF) begin
            v_enc = tes_pkg::ENC_UTF16BE;
            v_mark = 3'd2;
        end else if (ge3 && h0 == 8'hEF && h1 == 8'hBB && h2 == 8'hBF) begin
            v_enc = tes_pkg::ENC_UTF8;
            v_mark = 3'd3;
        end else if (ge5 && h0 == 8'h2B && h1 == 8'h2F && h2 == 8'h76 && h3 == 8'h38
                     && h4 == 8'h2D) begin
            v_enc = tes_pkg::ENC_UTF7;
            v_mark = 3'd5;
        end else if (ge4 && h0 == 8'h3C && h1 == 8'h00 && h2 == 8'h00 && h3 == 8'h00) begin
            v_enc = tes_pkg::ENC_UTF32LE;
        end else if (ge4 && h0 == 8'h00 && h1 == 8'h00 && h2 == 8'h00 && h3 == 8'h3C) begin
            v_enc = tes_pkg::ENC_UTF32BE;
        end else if (ge2 && h0 == 8'h3C && h1 == 8'h00) begin
            v_enc = tes_pkg::ENC_UTF16LE;
        end else if (ge2 && h0 == 8'h00 && h1 == 8'h3C) begin
            v_enc = tes_pkg::ENC_UTF16BE;
        end else if (!r_fin_flags[tes_pkg::ERR_UTF8]) begin
            v_enc = tes_pkg::ENC_UTF8;
        end else if (!r_fin_flags[tes_pkg::ERR_ZERO32] && t32le > size_w) begin
            v_enc = tes_pkg::ENC_UTF32LE;
        end else if (!r_fin_flags[tes_pkg::ERR_ZERO32] && t32be > size_w) begin
            v_enc = tes_pkg::ENC_UTF32BE;
        end else if (!r_fin_flags[tes_pkg::ERR_ZERO16] && t16le > size_w) begin
            v_enc = tes_pkg::ENC_UTF16LE;
        end else if (!r_fin_flags[tes_pkg::ERR_ZERO16] && t16be > size_w) begin
            v_enc = tes_pkg::ENC_UTF16BE;
        end else begin
            v_det = 1'b0;
            v_bin = r_fin_flags[tes_pkg::ERR_NULL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_can_load) begin
            r_out_valid <= r_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_move) begin
            r_out_enc  <= v_enc;
            r_out_mark <= v_mark;
            r_out_det  <= v_det;
            r_out_bin  <= v_bin;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.encoding       = r_out_enc;
    assign o_res.mark_bytes     = r_out_mark;
    assign o_res.detected       = r_out_det;
    assign o_res.binary_suspect = r_out_bin;

    `TES_ASSERT_NEXT(a_last_clears_count, i_clk, i_rst_n,
        in_accept && i_in.last_byte, r_count == '0 && r_fin_valid,
        "The last byte did not clear the scan state and fill the snapshot.")
    `TES_ASSERT_NEXT(a_snapshot_held, i_clk, i_rst_n,
        r_fin_valid && !out_can_load, r_fin_valid && $stable(r_fin_count),
        "A waiting snapshot was lost or overwritten.")
    `TES_ASSERT(a_phase_tracks_count, i_clk, i_rst_n,
        (r_count != {CW{1'b1}}) |-> (r_phase == r_count[1:0]),
        "Word phase is out of step with the byte count.")
    `TES_ASSERT(a_undecided_is_none, i_clk, i_rst_n,
        (r_out_valid && !r_out_det) |-> (r_out_enc == tes_pkg::ENC_NONE && r_out_mark == 3'd0),
        "An undecided verdict carries an encoding or a mark.")
    `TES_ASSERT(a_binary_only_undecided, i_clk, i_rst_n,
        (r_out_valid && r_out_bin) |-> !r_out_det,
        "Binary suspect is set on a decided verdict.")

endmodule

// File: dv/text_encoding_sniffer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for text_encoding_sniffer: file bytes in, one verdict per file out.
module text_encoding_sniffer_tb;

    localparam int CYCLE_LIMIT = 150000;

    localparam int MK_U32LE   = 0;
    localparam int MK_UCS4A   = 1;
    localparam int MK_U32BE   = 2;
    localparam int MK_UCS4B   = 3;
    localparam int MK_U16LE   = 4;
    localparam int MK_U16BE   = 5;
    localparam int MK_UTF8    = 6;
    localparam int MK_UTF7    = 7;
    localparam int MK_LT32LE  = 8;
    localparam int MK_LT32BE  = 9;
    localparam int MK_LT16LE  = 10;
    localparam int MK_LT16BE  = 11;

    typedef logic [7:0] t_file[$];

    typedef struct {
        tes_pkg::t_enc enc;
        logic [2:0]    mark;
        logic          det;
        logic          bin;
    } t_verdict;

    logic i_clk;
    logic i_rst_n;

    tes_in_if  in_if();
    tes_out_if res_if();

    text_encoding_sniffer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if)
    );

    logic [39:0]                     head_q;
    logic [tes_pkg::COUNT_WIDTH-1:0] size_q;
    logic [1:0]                      pend_q;
    logic [23:0]                     recent_q;
    logic [3:0]                      flags_q;
    logic [tes_pkg::COUNT_WIDTH-1:0] nl_q[4];
    logic [1:0]                      phase_q;

    t_verdict expected_verdicts[$];
    t_verdict want;
    int       error_count = 0;
    int       verdict_count = 0;
    int       cycle_count = 0;
    int       bytes_sent = 0;
    int       src_idle_max = 0;
    int       snk_idle_max = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [tes_pkg::COUNT_WIDTH-1:0] sat_inc(
        input logic [tes_pkg::COUNT_WIDTH-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    task automatic clear_tracker();
        head_q = '0;
        size_q = '0;
        pend_q = '0;
        recent_q = '0;
        flags_q = '0;
        for (int i = 0; i < 4; i++) nl_q[i] = '0;
        phase_q = '0;
    endtask

    function automatic bit head_is(input int n, input logic [39:0] pat);
        if (size_q < n) return 1'b0;
        for (int i = 0; i < n; i++) begin
            if (head_q[8*i +: 8] != pat[8*i +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_verdict judge_file();
        t_verdict v;
        v.enc = tes_pkg::ENC_NONE;
        v.mark = 3'd0;
        v.det = 1'b1;
        v.bin = 1'b0;
        if (size_q >= 2) begin
            if (head_is(4, 40'h000000FEFF)) begin
                v.enc = tes_pkg::ENC_UTF32LE; v.mark = 3'd4; return v;
            end
            if (head_is(4, 40'h000000FFFE)) begin
                v.enc = tes_pkg::ENC_UCS4; return v;
            end
            if (head_is(4, 40'h00FFFE0000)) begin
                v.enc = tes_pkg::ENC_UTF32BE; v.mark = 3'd4; return v;
            end
            if (head_is(4, 40'h00FEFF0000)) begin
                v.enc = tes_pkg::ENC_UCS4; return v;
            end
            if (head_is(2, 40'h000000FEFF)) begin
                v.enc = tes_pkg::ENC_UTF16LE; v.mark = 3'd2; return v;
            end
            if (head_is(2, 40'h000000FFFE)) begin
                v.enc = tes_pkg::ENC_UTF16BE; v.mark = 3'd2; return v;
            end
            if (head_is(3, 40'h0000BFBBEF)) begin
                v.enc = tes_pkg::ENC_UTF8; v.mark = 3'd3; return v;
            end
            if (head_is(5, 40'h2D38762F2B)) begin
                v.enc = tes_pkg::ENC_UTF7; v.mark = 3'd5; return v;
            end
            if (head_is(4, 40'h000000003C)) begin
                v.enc = tes_pkg::ENC_UTF32LE; return v;
            end
            if (head_is(4, 40'h003C000000)) begin
                v.enc = tes_pkg::ENC_UTF32BE; return v;
            end
            if (head_is(2, 40'h000000003C)) begin
                v.enc = tes_pkg::ENC_UTF16LE; return v;
            end
            if (head_is(2, 40'h0000003C00)) begin
                v.enc = tes_pkg::ENC_UTF16BE; return v;
            end
        end
        if (!flags_q[tes_pkg::ERR_UTF8]) begin
            v.enc = tes_pkg::ENC_UTF8; return v;
        end
        if (!flags_q[tes_pkg::ERR_ZERO32] && nl_q[tes_pkg::NL_32LE] > size_q / 400) begin
            v.enc = tes_pkg::ENC_UTF32LE; return v;
        end
        if (!flags_q[tes_pkg::ERR_ZERO32] && nl_q[tes_pkg::NL_32BE] > size_q / 400) begin
            v.enc = tes_pkg::ENC_UTF32BE; return v;
        end
        if (!flags_q[tes_pkg::ERR_ZERO16] && nl_q[tes_pkg::NL_16LE] > size_q / 200) begin
            v.enc = tes_pkg::ENC_UTF16LE; return v;
        end
        if (!flags_q[tes_pkg::ERR_ZERO16] && nl_q[tes_pkg::NL_16BE] > size_q / 200) begin
            v.enc = tes_pkg::ENC_UTF16BE; return v;
        end
        v.det = 1'b0;
        v.bin = flags_q[tes_pkg::ERR_NULL];
        return v;
    endfunction

    task automatic track_byte(input logic [7:0] b, input logic is_last);
        logic [7:0] r0;
        logic [7:0] r1;
        logic [7:0] r2;
        logic       mid0;
        r0 = recent_q[7:0];
        r1 = recent_q[15:8];
        r2 = recent_q[23:16];
        if (size_q < 5) head_q[8*size_q +: 8] = b;
        size_q = sat_inc(size_q);
        if (b == 8'h00) flags_q[tes_pkg::ERR_NULL] = 1'b1;

        if (pend_q == 2'd0) begin
            if (b[7:6] == 2'b10 || b == 8'h00) flags_q[tes_pkg::ERR_UTF8] = 1'b1;
            else if (!b[7]) pend_q = 2'd0;
            else if (b[7:5] == 3'b110) pend_q = 2'd1;
            else if (b[7:4] == 4'b1110) pend_q = 2'd2;
            else if (b[7:3] == 5'b11110) pend_q = 2'd3;
            else flags_q[tes_pkg::ERR_UTF8] = 1'b1;
        end else if (b[7:6] == 2'b10) begin
            pend_q = pend_q - 2'd1;
        end else begin
            flags_q[tes_pkg::ERR_UTF8] = 1'b1;
            pend_q = 2'd0;
        end

        if (phase_q[0]) begin
            if (r0 == 8'h00 && b == 8'h00) flags_q[tes_pkg::ERR_ZERO16] = 1'b1;
            if (r0 == 8'h0A && b == 8'h00) begin
                nl_q[tes_pkg::NL_16LE] = sat_inc(nl_q[tes_pkg::NL_16LE]);
            end
            if (r0 == 8'h00 && b == 8'h0A) begin
                nl_q[tes_pkg::NL_16BE] = sat_inc(nl_q[tes_pkg::NL_16BE]);
            end
        end
        if (phase_q == 2'd3) begin
            mid0 = (r1 == 8'h00 && r0 == 8'h00);
            if (r2 == 8'h00 && mid0 && b == 8'h00) flags_q[tes_pkg::ERR_ZERO32] = 1'b1;
            if (r2 == 8'h0A && mid0 && b == 8'h00) begin
                nl_q[tes_pkg::NL_32LE] = sat_inc(nl_q[tes_pkg::NL_32LE]);
            end
            if (r2 == 8'h00 && mid0 && b == 8'h0A) begin
                nl_q[tes_pkg::NL_32BE] = sat_inc(nl_q[tes_pkg::NL_32BE]);
            end
        end

        recent_q = {recent_q[15:0], b};
        phase_q = phase_q + 2'd1;

        if (is_last) begin
            expected_verdicts.push_back(judge_file());
            clear_tracker();
        end
    endtask

    function automatic t_file mark_prefix(input int idx);
        case (idx)
            MK_U32LE:  return '{8'hFF, 8'hFE, 8'h00, 8'h00};
            MK_UCS4A:  return '{8'hFE, 8'hFF, 8'h00, 8'h00};
            MK_U32BE:  return '{8'h00, 8'h00, 8'hFE, 8'hFF};
            MK_UCS4B:  return '{8'h00, 8'h00, 8'hFF, 8'hFE};
            MK_U16LE:  return '{8'hFF, 8'hFE};
            MK_U16BE:  return '{8'hFE, 8'hFF};
            MK_UTF8:   return '{8'hEF, 8'hBB, 8'hBF};
            MK_UTF7:   return '{8'h2B, 8'h2F, 8'h76, 8'h38, 8'h2D};
            MK_LT32LE: return '{8'h3C, 8'h00, 8'h00, 8'h00};
            MK_LT32BE: return '{8'h00, 8'h00, 8'h00, 8'h3C};
            MK_LT16LE: return '{8'h3C, 8'h00};
            default:   return '{8'h00, 8'h3C};
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'h0A;
            2: return 8'h3C;
            3: return 8'($urandom_range(8'h80, 8'hBF));
            4: return $urandom_range(0, 1) ? 8'hFE : 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_file make_utf8(input int chars);
        t_file f;
        int    n;
        for (int i = 0; i < chars; i++) begin
            n = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
            case (n)
                0: f.push_back(8'($urandom_range(8'h01, 8'h7F)));
                1: f.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                2: f.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                default: f.push_back(8'($urandom_range(8'hF0, 8'hF7)));
            endcase
            repeat (n) f.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        return f;
    endfunction

    function automatic t_file make_wide(input int word_bytes, input bit big, input int words,
                                        input int nl_permil, input int zero_permil);
        t_file       f;
        logic [31:0] v;
        int          r;
        for (int i = 0; i < words; i++) begin
            r = $urandom_range(0, 999);
            if (r < nl_permil) v = 32'h0000000A;
            else if (r < nl_permil + zero_permil) v = 32'h0;
            else if ($urandom_range(0, 7) == 0) v = $urandom & 32'h0010FFFF;
            else v = $urandom_range(32'h20, 32'h7E);
            for (int k = 0; k < word_bytes; k++) begin
                f.push_back(big ? v[8*(word_bytes-1-k) +: 8] : v[8*k +: 8]);
            end
        end
        return f;
    endfunction

    function automatic t_file make_file();
        t_file f;
        t_file body;
        int    kind;
        int    wb;
        int    len;
        int    pos;
        kind = $urandom_range(0, 39);
        wb = $urandom_range(0, 1) ? 2 : 4;
        if (kind == 0) begin
            f = make_wide(wb, $urandom_range(0, 1), $urandom_range(200, 460) / wb,
                          $urandom_range(0, 20), $urandom_range(0, 1) ? 0 : 2);
        end else if (kind <= 8) begin
            f = make_utf8($urandom_range(1, 12));
            if (f.size() > 1 && $urandom_range(0, 3) == 0) void'(f.pop_back());
        end else if (kind <= 13) begin
            f = make_utf8($urandom_range(1, 10));
            pos = $urandom_range(0, f.size() - 1);
            case ($urandom_range(0, 2))
                0: f[pos] = 8'h00;
                1: f[pos] = 8'($urandom_range(8'h80, 8'hBF));
                default: f[pos] = 8'($urandom_range(8'hF8, 8'hFF));
            endcase
        end else if (kind <= 21) begin
            f = make_wide(wb, $urandom_range(0, 1), $urandom_range(1, 10), 150, 40);
            if ($urandom_range(0, 5) == 0) f.push_front(pick_byte());
            if ($urandom_range(0, 5) == 0) f.push_back(pick_byte());
        end else if (kind <= 29) begin
            f = mark_prefix($urandom_range(MK_U32LE, MK_LT16BE));
            case ($urandom_range(0, 2))
                0: body = make_utf8($urandom_range(0, 6));
                1: body = make_wide(wb, $urandom_range(0, 1), $urandom_range(0, 4), 150, 40);
                default: begin
                    len = $urandom_range(0, 8);
                    repeat (len) body.push_back(pick_byte());
                end
            endcase
            foreach (body[i]) f.push_back(body[i]);
        end else if (kind <= 34) begin
            len = $urandom_range(1, 16);
            repeat (len) f.push_back(pick_byte());
        end else begin
            f = mark_prefix($urandom_range(MK_U32LE, MK_LT16BE));
            len = $urandom_range(1, f.size());
            while (f.size() > len) void'(f.pop_back());
            if ($urandom_range(0, 2) == 0) f[f.size() - 1] = pick_byte();
        end
        return f;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        gap = $urandom_range(0, src_idle_max);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data_byte <= b;
        in_if.last_byte <= is_last;
        do @(posedge i_clk); while (!in_if.ready);
        track_byte(b, is_last);
        bytes_sent++;
    endtask

    task automatic send_file(input t_file f);
        for (int i = 0; i < f.size(); i++) send_byte(f[i], i == f.size() - 1);
    endtask

    task automatic report_mismatch(input string what, input logic [2:0] exp_val,
                                   input logic [2:0] got_val);
        $display("verdict %0d: %s expected %0d, got %0d", verdict_count, what, exp_val, got_val);
        error_count++;
    endtask

    task automatic test_directed_files();
        src_idle_max = 0;
        snk_idle_max = 0;
        send_file(mark_prefix(MK_U32LE));
        send_file(mark_prefix(MK_U32BE));
        send_file(mark_prefix(MK_U16BE));
        send_file(mark_prefix(MK_UTF8));
        send_file(mark_prefix(MK_UTF7));
        send_file(mark_prefix(MK_LT16BE));
        send_file('{8'h00});
        send_file('{8'hFF});
        send_file('{8'h41, 8'h0A, 8'h80});
    endtask

    task automatic test_random_files(input int n_bytes, input int src_max, input int snk_max);
        int stop_at;
        src_idle_max = src_max;
        snk_idle_max = snk_max;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) send_file(make_file());
    endtask

    task automatic test_pause_for_verdicts();
        src_idle_max = 13;
        snk_idle_max = 13;
        repeat (3) send_file(make_file());
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (2) send_file(make_file());
    endtask

    initial begin : verdict_sink
        int stall;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, snk_idle_max);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_if.valid && res_if.ready));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            verdict_count++;
            if (expected_verdicts.size() == 0) begin
                report_mismatch("verdict with none pending, encoding", 3'd0, res_if.encoding);
            end else begin
                want = expected_verdicts.pop_front();
                if (res_if.encoding !== want.enc)
                    report_mismatch("encoding", want.enc, res_if.encoding);
                if (res_if.mark_bytes !== want.mark)
                    report_mismatch("mark_bytes", want.mark, res_if.mark_bytes);
                if (res_if.detected !== want.det)
                    report_mismatch("detected", {2'b00, want.det}, {2'b00, res_if.detected});
                if (res_if.binary_suspect !== want.bin)
                    report_mismatch("binary_suspect", {2'b00, want.bin},
                                    {2'b00, res_if.binary_suspect});
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("text_encoding_sniffer_tb: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data_byte = 8'h00;
        in_if.last_byte = 1'b0;
        clear_tracker();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_files();
        test_random_files(250, 13, 13);
        test_random_files(150, 0, 13);
        test_pause_for_verdicts();
        test_random_files(150, 13, 0);
        test_random_files(150, 0, 0);

        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("text_encoding_sniffer_tb: clean");
        end else begin
            $display("text_encoding_sniffer_tb: errors");
        end
        $finish;
    end

endmodule
